@@ sv/rcfp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcfp_pkg : shared types and constants of the RC channel frame parser
// Request and result structs, result kinds, header bytes and frame positions.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int unsigned STORE_WORDS   = 14;
  localparam int unsigned IDX_W         = $clog2(STORE_WORDS);
  localparam int unsigned CHANNEL_COUNT = 14;

  localparam logic [7:0]  HDR_FIRST     = 8'h20;
  localparam logic [7:0]  HDR_SECOND    = 8'h40;
  localparam logic [15:0] SUM_SEED      = 16'hFFFF;
  localparam logic [15:0] HDR_SUM       = 16'h0060;

  localparam logic [5:0]  POS_HUNT      = 6'd0;
  localparam logic [5:0]  POS_HDR2      = 6'd1;
  localparam logic [5:0]  POS_DATA0     = 6'd2;
  localparam logic [5:0]  POS_CK_LO     = 6'd30;
  localparam logic [5:0]  POS_CK_HI     = 6'd31;

  localparam logic [15:0] LOW_LIMIT_RST  = 16'd800;
  localparam logic [15:0] HIGH_LIMIT_RST = 16'd2200;

  localparam logic        CFG_LOW_LIMIT  = 1'b0;
  localparam logic        CFG_HIGH_LIMIT = 1'b1;

  localparam logic        REQ_BYTE       = 1'b0;
  localparam logic        REQ_LINE_ERR   = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHANNEL   = 2'd0,
    KIND_BAD_FRAME = 2'd1,
    KIND_LINE_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CHECK,
    ST_BAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [3:0]  channel_number;
    logic [15:0] channel_value;
    logic        last_of_run;
    logic [31:0] good_frames;
    logic [31:0] bad_events;
  } result_t;

endpackage
`default_nettype wire

@@ sv/rc_channel_frame_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc_channel_frame_parser_core : 32-byte RC receiver frame parser
// Hunts the 0x20 0x40 header, stores channel words, checks sum and limits,
// and emits channel values or one error result per bad frame or line error.
// ----------------------------------------------------------------------------
// A byte request is taken while the parser is in its run state and the
// output register is free. The final byte of a frame with a good checksum
// starts two passes over the 14-word frame memory, which has a single
// registered read port: a limit check of one word per cycle (up to
// CHANNEL_COUNT words) and then one channel result per cycle while the
// consumer keeps out_ready high. No request is taken during these passes.
// A line error or a bad frame gives its single result from the output
// register while the next request is already taken.
module rc_channel_frame_parser_core #(
  parameter int unsigned CHANNEL_COUNT = rcfp_pkg::CHANNEL_COUNT
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  rcfp_pkg::req_t        in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output rcfp_pkg::result_t     out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire  [15:0]           cfg_data
);

  localparam int unsigned IW = rcfp_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNEL_COUNT - 1);

  rcfp_pkg::state_t  state_r, state_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        lo_hold_r, lo_hold_nxt;
  logic [7:0]        ck_lo_r, ck_lo_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [31:0]       good_r, good_nxt;
  logic [31:0]       bad_r, bad_nxt;
  logic [15:0]       low_lim_r, high_lim_r;
  logic              out_valid_r, out_valid_nxt;
  rcfp_pkg::result_t out_data_r, out_data_nxt;

  logic [15:0]       frame_mem [rcfp_pkg::STORE_WORDS];
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [15:0]       rd_data_r;

  logic              out_free;
  logic              in_fire;
  logic [5:0]        pos_off;
  logic [15:0]       ck_got;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == rcfp_pkg::ST_RUN) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pos_off   = pos_r - rcfp_pkg::POS_DATA0;
  assign ck_got    = {in_data.rx_byte, ck_lo_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= frame_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    lo_hold_nxt   = lo_hold_r;
    ck_lo_nxt     = ck_lo_r;
    idx_nxt       = idx_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_off[IW:1];
    mem_wdata     = {in_data.rx_byte, lo_hold_r};
    rd_en         = 1'b0;
    rd_addr       = '0;

    unique case (state_r)
      rcfp_pkg::ST_RUN: begin
        if (in_fire) begin
          if (in_data.req_type == rcfp_pkg::REQ_LINE_ERR) begin
            pos_nxt                     = rcfp_pkg::POS_HUNT;
            bad_nxt                     = bad_r + 32'd1;
            out_valid_nxt               = 1'b1;
            out_data_nxt.result_kind    = rcfp_pkg::KIND_LINE_ERR;
            out_data_nxt.channel_number = '0;
            out_data_nxt.channel_value  = '0;
            out_data_nxt.last_of_run    = 1'b1;
            out_data_nxt.good_frames    = good_r;
            out_data_nxt.bad_events     = bad_nxt;
          end else if (pos_r == rcfp_pkg::POS_HUNT) begin
            if (in_data.rx_byte == rcfp_pkg::HDR_FIRST) begin
              pos_nxt = rcfp_pkg::POS_HDR2;
            end
          end else if (pos_r == rcfp_pkg::POS_HDR2) begin
            if (in_data.rx_byte == rcfp_pkg::HDR_SECOND) begin
              pos_nxt = rcfp_pkg::POS_DATA0;
              sum_nxt = rcfp_pkg::HDR_SUM;
            end else if (in_data.rx_byte == rcfp_pkg::HDR_FIRST) begin
              pos_nxt = rcfp_pkg::POS_HDR2;
            end else begin
              pos_nxt = rcfp_pkg::POS_HUNT;
            end
          end else if (pos_r == rcfp_pkg::POS_CK_LO) begin
            ck_lo_nxt = in_data.rx_byte;
            pos_nxt   = rcfp_pkg::POS_CK_HI;
          end else if (pos_r < rcfp_pkg::POS_CK_LO) begin
            if (!pos_off[0]) begin
              lo_hold_nxt = in_data.rx_byte;
            end else begin
              mem_we = 1'b1;
            end
            sum_nxt = sum_r + {8'd0, in_data.rx_byte};
            pos_nxt = pos_r + 6'd1;
          end else begin
            pos_nxt = rcfp_pkg::POS_HUNT;
            if (ck_got == (rcfp_pkg::SUM_SEED - sum_r)) begin
              state_nxt = rcfp_pkg::ST_CHECK;
              idx_nxt   = '0;
              rd_en     = 1'b1;
            end else begin
              bad_nxt                     = bad_r + 32'd1;
              out_valid_nxt               = 1'b1;
              out_data_nxt.result_kind    = rcfp_pkg::KIND_BAD_FRAME;
              out_data_nxt.channel_number = '0;
              out_data_nxt.channel_value  = '0;
              out_data_nxt.last_of_run    = 1'b1;
              out_data_nxt.good_frames    = good_r;
              out_data_nxt.bad_events     = bad_nxt;
            end
          end
        end
      end
      rcfp_pkg::ST_CHECK: begin
        if (rd_data_r < low_lim_r || rd_data_r > high_lim_r) begin
          state_nxt = rcfp_pkg::ST_BAD;
        end else if (idx_r == LAST_IDX) begin
          good_nxt  = good_r + 32'd1;
          state_nxt = rcfp_pkg::ST_EMIT;
          idx_nxt   = '0;
          rd_en     = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_nxt;
        end
      end
      rcfp_pkg::ST_BAD: begin
        if (out_free) begin
          bad_nxt                     = bad_r + 32'd1;
          state_nxt                   = rcfp_pkg::ST_RUN;
          out_valid_nxt               = 1'b1;
          out_data_nxt.result_kind    = rcfp_pkg::KIND_BAD_FRAME;
          out_data_nxt.channel_number = '0;
          out_data_nxt.channel_value  = '0;
          out_data_nxt.last_of_run    = 1'b1;
          out_data_nxt.good_frames    = good_r;
          out_data_nxt.bad_events     = bad_nxt;
        end
      end
      rcfp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.result_kind    = rcfp_pkg::KIND_CHANNEL;
          out_data_nxt.channel_number = 4'(idx_r);
          out_data_nxt.channel_value  = rd_data_r;
          out_data_nxt.last_of_run    = (idx_r == LAST_IDX);
          out_data_nxt.good_frames    = good_r;
          out_data_nxt.bad_events     = bad_r;
          if (idx_r == LAST_IDX) begin
            state_nxt = rcfp_pkg::ST_RUN;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_nxt;
          end
        end
      end
      default: begin
        state_nxt = rcfp_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcfp_pkg::ST_RUN;
      pos_r       <= rcfp_pkg::POS_HUNT;
      sum_r       <= '0;
      idx_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_hold_r  <= lo_hold_nxt;
    ck_lo_r    <= ck_lo_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_lim_r  <= rcfp_pkg::LOW_LIMIT_RST;
      high_lim_r <= rcfp_pkg::HIGH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcfp_pkg::CFG_LOW_LIMIT:  low_lim_r  <= cfg_data;
        rcfp_pkg::CFG_HIGH_LIMIT: high_lim_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
